>>> rtl/core/sng_pkg.sv
// Shared types, constants and helper functions of the square/noise sound generator.
package sng_pkg;

    localparam int NUM_TONES = 3;
    localparam int CHAN_W    = 2;

    // Per-channel tone state kept in the tone RAM.
    typedef struct packed {
        logic [9:0] period;
        logic [9:0] count;
        logic       level;
    } tone_t;

    localparam int TONE_W = $bits(tone_t);

    localparam tone_t TONE_RESET = '{period: 10'd1, count: 10'd1, level: 1'b0};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_T0,
        ST_T1,
        ST_T2
    } sng_state_t;

    localparam logic [CHAN_W-1:0] NOISE_CHAN = 2'd3;

    localparam logic [1:0] RATE_16  = 2'd0;
    localparam logic [1:0] RATE_32  = 2'd1;
    localparam logic [1:0] RATE_64  = 2'd2;

    localparam logic [15:0] SHIFT_RESET       = 16'h8000;
    localparam logic [9:0]  NOISE_COUNT_RESET = 10'h010;

    // Low-pass filter coefficients, Q16.
    localparam logic signed [13:0] COEF_IN    = 14'sd2517;
    localparam logic signed [16:0] COEF_FB    = 17'sd60504;
    localparam logic signed [33:0] ROUND_BIAS = 34'sd65535;
    localparam logic signed [17:0] SAT_MAX    = 18'sd32767;
    localparam logic signed [17:0] SAT_MIN    = -18'sd32768;

    // Attenuation to amplitude, 2 dB steps, last code silent.
    function automatic logic [13:0] amp_of(input logic [3:0] att);
        logic [13:0] a;
        case (att)
            4'd0:    a = 14'h1FFF;
            4'd1:    a = 14'h196A;
            4'd2:    a = 14'h1430;
            4'd3:    a = 14'h1009;
            4'd4:    a = 14'h0CBD;
            4'd5:    a = 14'h0A1E;
            4'd6:    a = 14'h0809;
            4'd7:    a = 14'h0662;
            4'd8:    a = 14'h0512;
            4'd9:    a = 14'h0407;
            4'd10:   a = 14'h0333;
            4'd11:   a = 14'h028A;
            4'd12:   a = 14'h0204;
            4'd13:   a = 14'h019A;
            4'd14:   a = 14'h0146;
            default: a = 14'h0000;
        endcase
        return a;
    endfunction

    function automatic logic signed [15:0] signed_amp(input logic level, input logic [3:0] att);
        logic signed [15:0] a;
        a = $signed({2'b00, amp_of(att)});
        return level ? a : -a;
    endfunction

endpackage

>>> rtl/core/sng_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/sng_filter.sv
// First-order low-pass filter, saturation and output register.
module sng_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mix_valid,
    output logic               mix_ready,
    input  logic signed [15:0] mix,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata    // [15:0] sample
);

    import sng_pkg::*;

    logic signed [15:0] in_prev_reg;
    logic signed [15:0] out_prev_reg;
    logic signed [30:0] p_in_reg;
    logic signed [32:0] p_fb_reg;
    logic               prod_valid_reg;
    logic               out_valid_reg;
    logic [15:0]        sample_reg;

    logic signed [16:0] in_sum;
    logic signed [30:0] p_in_next;
    logic signed [32:0] p_fb_next;
    logic signed [33:0] acc;
    logic signed [33:0] acc_adj;
    logic signed [17:0] quo;
    logic signed [15:0] sat;
    logic               load_prod;
    logic               load_out;

    // Product stage loads only when empty, so the feedback value is settled.
    assign mix_ready = !prod_valid_reg;
    assign load_prod = mix_valid && !prod_valid_reg;
    assign load_out  = prod_valid_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        in_sum    = 17'(mix) + 17'(in_prev_reg);
        p_in_next = 31'(in_sum) * 31'(COEF_IN);
        p_fb_next = 33'(out_prev_reg) * 33'(COEF_FB);
        acc       = 34'(p_in_reg) + 34'(p_fb_reg);
        // truncate toward zero
        acc_adj   = acc + (acc[33] ? ROUND_BIAS : 34'sd0);
        quo       = $signed(acc_adj[33:16]);
        if (quo > SAT_MAX)
        begin
            sat = 16'sd32767;
        end
        else if (quo < SAT_MIN)
        begin
            sat = -16'sd32768;
        end
        else
        begin
            sat = quo[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_prev_reg    <= '0;
            out_prev_reg   <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_prod)
            begin
                in_prev_reg    <= mix;
                prod_valid_reg <= 1'b1;
            end
            else if (load_out)
            begin
                prod_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_prev_reg  <= sat;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            p_in_reg <= p_in_next;
            p_fb_reg <= p_fb_next;
        end
        if (load_out)
        begin
            sample_reg <= sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = sample_reg;

endmodule

>>> rtl/core/square_noise_sound_generator.sv
// Top level of the square/noise sound generator: three tones, one noise channel, filter.
//
// Input channel (s_axis): one item is either a register byte (tuser = 0) or a sample
// tick (tuser = 1). Register bytes follow the latch/data convention: bit 7 set latches
// channel and type; either byte writes volume or noise control, or period bits: the
// low ones if latching, else the high. A tick steps every counter and yields one sample.
// Output channel (m_axis): one signed 16-bit filtered sample per tick, none per write.
//
// Sequencing: the tone state (period, counter, level) of the three tones sits in a small
// RAM with registered read data. A tick walks the three entries, one read-modify-write
// per cycle unless a stall holds the walk, and a new item is taken only as the walk
// ends; the sample then passes the mix, product and output registers. Volume and
// noise writes leave the sequencer idle; tone period writes do a read-modify-write
// and accept the next item in the following cycle. Back-to-back accesses to one entry
// are covered by a write-to-read bypass.
//
// Reset: all control state clears; RAM entries read as their reset value until first
// written (per-entry valid flops), so no clearing pass is needed.
// Stall: a held output register backs up the product and mix stages; the tick walk
// then holds on its last step and no new item is accepted until the filter takes the mix.
module square_noise_sound_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] cmd: 0 register write, 1 tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] sample
);

    import sng_pkg::*;

    sng_state_t         state_reg, state_next;

    // pending tone period write
    logic [CHAN_W-1:0]  wr_chan_reg;
    logic [7:0]         wr_byte_reg;
    logic               wr_latch_reg;

    logic [2:0]         latched_target_reg;
    logic [3:0]         att_reg [4];
    logic [2:0]         noise_mode_reg;
    logic [9:0]         noise_count_reg;
    logic [15:0]        shift_reg;
    logic               half_rate_reg;
    logic               noise_level_reg;

    logic signed [15:0] mix_acc_reg;
    logic signed [15:0] mix_reg;
    logic               mix_valid_reg;
    logic               mix_ready;

    // tone RAM and its read bypass
    logic [NUM_TONES-1:0] tone_valid_reg;
    logic                 rd_ok_reg;
    logic                 byp_hit_reg;
    tone_t                byp_data_reg;
    logic                 ram_we;
    logic [CHAN_W-1:0]    ram_waddr;
    logic [CHAN_W-1:0]    ram_raddr;
    logic [TONE_W-1:0]    ram_wdata;
    logic [TONE_W-1:0]    ram_rdata;

    logic                 accept;
    logic                 acc_tick;
    logic                 acc_latch;
    logic [2:0]           acc_target;
    logic [CHAN_W-1:0]    acc_chan;
    logic                 acc_is_att;
    logic                 acc_is_tone;
    logic                 acc_is_noise;

    tone_t                tone_cur;
    tone_t                tone_upd;
    tone_t                tone_wr;
    logic [9:0]           cnt_dec;
    logic [CHAN_W-1:0]    chan_idx;
    logic signed [15:0]   tone_amp;
    logic                 t2_go;
    logic                 go;

    logic [9:0]           nc_dec;
    logic [9:0]           nc_next;
    logic                 half_next;
    logic [15:0]          sr_next;
    logic                 nl_next;
    logic                 fb;
    logic signed [15:0]   noise_amp;

    // ---------------- input decode ----------------
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign acc_tick   = s_axis_tuser[0];
    assign acc_latch  = s_axis_tdata[7];
    assign acc_target = acc_latch ? s_axis_tdata[6:4] : latched_target_reg;
    assign acc_chan   = acc_target[2:1];
    assign acc_is_att   = acc_target[0];
    assign acc_is_tone  = !acc_target[0] && (acc_chan != NOISE_CHAN);
    assign acc_is_noise = !acc_target[0] && (acc_chan == NOISE_CHAN);

    // ---------------- tone entry modify ----------------
    always_comb
    begin
        if (byp_hit_reg)
        begin
            tone_cur = byp_data_reg;
        end
        else if (rd_ok_reg)
        begin
            tone_cur = tone_t'(ram_rdata);
        end
        else
        begin
            tone_cur = TONE_RESET;
        end

        tone_upd = tone_cur;
        cnt_dec  = tone_cur.count - 10'd1;
        if (cnt_dec == 10'd0)
        begin
            tone_upd.count = (tone_cur.period == 10'd0) ? 10'd1 : tone_cur.period;
            tone_upd.level = ~tone_cur.level;
        end
        else
        begin
            tone_upd.count = cnt_dec;
        end

        tone_wr = tone_cur;
        if (wr_latch_reg)
        begin
            tone_wr.period = {tone_cur.period[9:4], wr_byte_reg[3:0]};
        end
        else
        begin
            tone_wr.period = {wr_byte_reg[5:0], tone_cur.period[3:0]};
        end

        case (state_reg)
            ST_T0:   chan_idx = 2'd0;
            ST_T1:   chan_idx = 2'd1;
            default: chan_idx = 2'd2;
        endcase

        tone_amp = signed_amp(tone_upd.level, att_reg[chan_idx]);
    end

    // ---------------- noise step (on last tick step) ----------------
    always_comb
    begin
        nc_dec    = noise_count_reg - 10'd1;
        nc_next   = nc_dec;
        half_next = half_rate_reg;
        sr_next   = shift_reg;
        nl_next   = noise_level_reg;
        fb        = noise_mode_reg[2] ? (shift_reg[0] ^ shift_reg[3]) : shift_reg[0];
        if (nc_dec == 10'd0)
        begin
            case (noise_mode_reg[1:0])
                RATE_16: nc_next = 10'h010;
                RATE_32: nc_next = 10'h020;
                RATE_64: nc_next = 10'h040;
                default: nc_next = (tone_cur.period == 10'd0) ? 10'd1 : tone_cur.period;
            endcase
            half_next = ~half_rate_reg;
            if (!half_rate_reg)
            begin
                sr_next = {fb, shift_reg[15:1]};
                nl_next = shift_reg[1];
            end
        end
        noise_amp = signed_amp(nl_next, att_reg[NOISE_CHAN]);
    end

    // ---------------- sequencer ----------------
    assign go    = !mix_valid_reg || mix_ready;
    assign t2_go = (state_reg == ST_T2) && go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = chan_idx;
        ram_wdata     = tone_upd;
        ram_raddr     = 2'd2;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_WR:
            begin
                s_axis_tready = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = wr_chan_reg;
                ram_wdata     = tone_wr;
                state_next    = ST_IDLE;
            end
            ST_T0:
            begin
                ram_we     = 1'b1;
                ram_raddr  = 2'd1;
                state_next = ST_T1;
            end
            ST_T1:
            begin
                ram_we     = 1'b1;
                ram_raddr  = 2'd2;
                state_next = ST_T2;
            end
            ST_T2:
            begin
                if (go)
                begin
                    ram_we        = 1'b1;
                    s_axis_tready = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (s_axis_tvalid && s_axis_tready)
        begin
            if (acc_tick)
            begin
                ram_raddr  = 2'd0;
                state_next = ST_T0;
            end
            else if (acc_is_tone)
            begin
                ram_raddr  = acc_chan;
                state_next = ST_WR;
            end
        end
    end

    // ---------------- tone RAM ----------------
    sng_ram #(
        .WIDTH (TONE_W),
        .DEPTH (NUM_TONES)
    ) u_tone_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_valid_reg <= '0;
            rd_ok_reg      <= 1'b0;
            byp_hit_reg    <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                tone_valid_reg[ram_waddr] <= 1'b1;
            end
            rd_ok_reg   <= tone_valid_reg[ram_raddr];
            byp_hit_reg <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= tone_t'(ram_wdata);
        if (accept)
        begin
            wr_chan_reg  <= acc_chan;
            wr_byte_reg  <= s_axis_tdata;
            wr_latch_reg <= acc_latch;
        end
    end

    // ---------------- registers, noise and mix ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_target_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                att_reg[i] <= 4'hF;
            end
            noise_mode_reg  <= '0;
            noise_count_reg <= NOISE_COUNT_RESET;
            shift_reg       <= SHIFT_RESET;
            half_rate_reg   <= 1'b0;
            noise_level_reg <= 1'b0;
            mix_acc_reg     <= '0;
            mix_valid_reg   <= 1'b0;
        end
        else
        begin
            if (t2_go)
            begin
                noise_count_reg <= nc_next;
                half_rate_reg   <= half_next;
                noise_level_reg <= nl_next;
            end

            // tick noise step comes first; a noise write taken in the same cycle follows it
            if (accept && !acc_tick && acc_is_noise)
            begin
                shift_reg <= SHIFT_RESET;
            end
            else if (t2_go)
            begin
                shift_reg <= sr_next;
            end

            if (accept && !acc_tick)
            begin
                if (acc_latch)
                begin
                    latched_target_reg <= s_axis_tdata[6:4];
                end
                if (acc_is_att)
                begin
                    att_reg[acc_chan] <= s_axis_tdata[3:0];
                end
                if (acc_is_noise)
                begin
                    noise_mode_reg <= s_axis_tdata[2:0];
                end
            end

            case (state_reg)
                ST_T0:   mix_acc_reg <= tone_amp;
                ST_T1:   mix_acc_reg <= mix_acc_reg + tone_amp;
                default: mix_acc_reg <= mix_acc_reg;
            endcase

            if (t2_go)
            begin
                mix_valid_reg <= 1'b1;
            end
            else if (mix_ready)
            begin
                mix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (t2_go)
        begin
            mix_reg <= mix_acc_reg + tone_amp + noise_amp;
        end
    end

    // ---------------- filter and output ----------------
    sng_filter u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .mix_valid     (mix_valid_reg),
        .mix_ready     (mix_ready),
        .mix           (mix_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
